[sv/vlff_pkg.sv]
package vlff_pkg;

    localparam int CHUNK_CELLS   = 16;
    localparam int HEIGHT_LAYERS = 128;
    localparam int QUEUE_DEPTH   = 4096;
    localparam int WIN_CELLS     = 3 * CHUNK_CELLS;
    localparam int STORE_DEPTH   = WIN_CELLS * WIN_CELLS * HEIGHT_LAYERS;

    localparam int WW = $clog2(WIN_CELLS);
    localparam int YW = $clog2(HEIGHT_LAYERS);
    localparam int AW = $clog2(STORE_DEPTH);
    localparam int QW = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] REQ_WR_OPAQUE = 2'd0;
    localparam logic [1:0] REQ_WR_LIGHT  = 2'd1;
    localparam logic [1:0] REQ_RD_LIGHT  = 2'd2;
    localparam logic [1:0] REQ_FILL      = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_WINDOW   = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    localparam logic [2:0] REG_WIN_X  = 3'd0;
    localparam logic [2:0] REG_WIN_Z  = 3'd1;
    localparam logic [2:0] REG_MIN_X  = 3'd2;
    localparam logic [2:0] REG_END_X  = 3'd3;
    localparam logic [2:0] REG_MIN_Y  = 3'd4;
    localparam logic [2:0] REG_TOP_Y  = 3'd5;
    localparam logic [2:0] REG_MIN_Z  = 3'd6;
    localparam logic [2:0] REG_END_Z  = 3'd7;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_RMW,
        S_OFFER_WR,
        S_POP,
        S_POP_WAIT,
        S_NB
    } state_t;

    typedef struct packed {
        logic [3:0]    v;
        logic [YW-1:0] y;
        logic [WW-1:0] wz;
        logic [WW-1:0] wx;
    } q_entry_t;

    function automatic logic [AW-1:0] cell_addr(input logic [WW-1:0] wx,
                                                input logic [WW-1:0] wz,
                                                input logic [YW-1:0] y);
        logic [AW-1:0] col;
        col = AW'(wz) * AW'(WIN_CELLS) + AW'(wx);
        return AW'(col * AW'(HEIGHT_LAYERS)) + AW'(y);
    endfunction

endpackage

[sv/voxel_light_flood_fill.sv]
// sequence: reads and writes go through decode, then a read-modify-write of the light store;
//   out-of-window items and fills that light nothing end in decode; a fill offers the seed,
//   then pops each cell, tries each neighbor and offers those in region and window a level
// throughput: one item at a time, the next taken at the edge that takes the result
// reset: registers to defaults, then a clearing pass zeroes all 294912 cells, one per cycle,
//   with busy high; configuration writes are taken meanwhile; the receiver cannot stall
module voxel_light_flood_fill import vlff_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         req_type,
    input  logic signed [23:0] pos_x,
    input  logic [6:0]         pos_y,
    input  logic signed [23:0] pos_z,
    input  logic [3:0]         level,
    input  logic               opaque,
    output logic               done,
    output logic [3:0]         read_level,
    output logic [1:0]         status,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // configuration registers
    logic signed [19:0] win_x_reg, win_z_reg;
    logic signed [23:0] min_x_reg, end_x_reg, min_z_reg, end_z_reg;
    logic [6:0]         min_y_reg, top_y_reg;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_x_reg <= '0;
            win_z_reg <= '0;
            min_x_reg <= '0;
            end_x_reg <= '0;
            min_y_reg <= '0;
            top_y_reg <= 7'd127;
            min_z_reg <= '0;
            end_z_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[4:2])
                REG_WIN_X: win_x_reg <= pwdata[19:0];
                REG_WIN_Z: win_z_reg <= pwdata[19:0];
                REG_MIN_X: min_x_reg <= pwdata[23:0];
                REG_END_X: end_x_reg <= pwdata[23:0];
                REG_MIN_Y: min_y_reg <= pwdata[6:0];
                REG_TOP_Y: top_y_reg <= pwdata[6:0];
                REG_MIN_Z: min_z_reg <= pwdata[23:0];
                REG_END_Z: end_z_reg <= pwdata[23:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_WIN_X: prdata = 32'(unsigned'(win_x_reg));
            REG_WIN_Z: prdata = 32'(unsigned'(win_z_reg));
            REG_MIN_X: prdata = 32'(unsigned'(min_x_reg));
            REG_END_X: prdata = 32'(unsigned'(end_x_reg));
            REG_MIN_Y: prdata = 32'(min_y_reg);
            REG_TOP_Y: prdata = 32'(top_y_reg);
            REG_MIN_Z: prdata = 32'(unsigned'(min_z_reg));
            REG_END_Z: prdata = 32'(unsigned'(end_z_reg));
            default:   prdata = '0;
        endcase
    end

    // window origin in world cells: (chunk - 1) * 16
    logic signed [21:0] bch_x, bch_z;
    logic signed [25:0] base_x, base_z;
    assign bch_x  = 22'(win_x_reg) - 22'sd1;
    assign bch_z  = 22'(win_z_reg) - 22'sd1;
    assign base_x = {bch_x, 4'b0};
    assign base_z = {bch_z, 4'b0};

    // locate the incoming item in the window
    logic signed [25:0] in_wx, in_wz;
    logic               in_win;
    assign in_wx  = 26'(pos_x) - base_x;
    assign in_wz  = 26'(pos_z) - base_z;
    assign in_win = (in_wx >= 0) && (in_wx < 26'sd48) && (in_wz >= 0) && (in_wz < 26'sd48)
                    && ({1'b0, pos_y} < 8'(HEIGHT_LAYERS));

    state_t state_reg, state_next;

    // latched item
    logic [1:0]         req_reg;
    logic signed [23:0] px_reg, pz_reg;
    logic [YW-1:0]      py_reg;
    logic [3:0]         lvl_reg;
    logic               opq_reg, inwin_reg;
    logic [WW-1:0]      iwx_reg, iwz_reg;

    // flood state
    logic [AW-1:0]      clr_reg, clr_next;
    logic [AW-1:0]      addr_reg, addr_next;
    q_entry_t           cur_reg, cur_next;      // cell being popped
    q_entry_t           ent_reg, ent_next;      // cell being offered
    logic               seed_reg, seed_next;
    logic [1:0]         dx_reg, dy_reg, dz_reg, dx_next, dy_next, dz_next;
    logic [QW-1:0]      head_reg, head_next, tail_reg, tail_next;
    logic [QW:0]        cnt_reg, cnt_next;
    logic               fwin_reg, fwin_next, fovf_reg, fovf_next;
    logic               done_reg, done_next;
    logic [3:0]         rd_lvl_reg, rd_lvl_next;
    logic [1:0]         stat_reg, stat_next;

    // memories: light store holds {opacity, level}, queue holds packed cells
    logic [4:0]         lmem [STORE_DEPTH];
    logic [4:0]         lmem_rd;
    logic               lmem_we;
    logic [AW-1:0]      lmem_addr;
    logic [4:0]         lmem_wd;
    q_entry_t           qmem [QUEUE_DEPTH];
    q_entry_t           qmem_rd;
    logic               qmem_we;

    always_ff @(posedge clk)
    begin
        if (lmem_we)
        begin
            lmem[lmem_addr] <= lmem_wd;
        end
        lmem_rd <= lmem[lmem_addr];
    end

    always_ff @(posedge clk)
    begin
        if (qmem_we)
        begin
            qmem[tail_reg] <= ent_reg;
        end
        qmem_rd <= qmem[head_reg];
    end

    // neighbor under test: offsets are counter minus one
    logic signed [7:0]  nwx, nwz;
    logic signed [8:0]  ny;
    logic signed [25:0] nworld_x, nworld_z;
    logic [1:0]         nb_dist;
    logic               nb_region, nb_win, nb_live, nb_last;
    logic [AW-1:0]      nb_addr;
    logic               seed_region;

    assign nwx = 8'(cur_reg.wx) + 8'(dx_reg) - 8'sd1;
    assign nwz = 8'(cur_reg.wz) + 8'(dz_reg) - 8'sd1;
    assign ny  = 9'(cur_reg.y) + 9'(dy_reg) - 9'sd1;
    assign nworld_x = base_x + 26'(nwx);
    assign nworld_z = base_z + 26'(nwz);
    assign nb_dist = 2'(dx_reg != 2'd1) + 2'(dy_reg != 2'd1) + 2'(dz_reg != 2'd1);
    assign nb_region = (nworld_x >= 26'(min_x_reg)) && (nworld_x < 26'(end_x_reg))
                       && (nworld_z >= 26'(min_z_reg)) && (nworld_z < 26'(end_z_reg))
                       && (ny >= $signed(9'(min_y_reg))) && (ny <= $signed(9'(top_y_reg)));
    assign nb_live = nb_region && (cur_reg.v > 4'(nb_dist));
    assign nb_win  = (nwx >= 0) && (nwx < 8'sd48) && (nwz >= 0) && (nwz < 8'sd48)
                     && (ny >= 0) && (ny < 9'(HEIGHT_LAYERS));
    assign nb_addr = cell_addr(nwx[WW-1:0], nwz[WW-1:0], ny[YW-1:0]);
    assign nb_last = (dx_reg == 2'd2) && (dy_reg == 2'd2) && (dz_reg == 2'd2);

    assign seed_region = (px_reg >= min_x_reg) && (px_reg < end_x_reg)
                         && (pz_reg >= min_z_reg) && (pz_reg < end_z_reg)
                         && (py_reg >= min_y_reg) && (py_reg <= top_y_reg);

    assign busy = (state_reg != S_IDLE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == AW'(STORE_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (!inwin_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (req_reg != REQ_FILL)
                begin
                    state_next = S_RMW;
                end
                else if (seed_region && (lvl_reg != 4'd0))
                begin
                    state_next = S_OFFER_WR;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_RMW:      state_next = S_IDLE;
            S_OFFER_WR: state_next = (seed_reg || nb_last) ? S_POP : S_NB;
            S_POP:      state_next = (cnt_reg == '0) ? S_IDLE : S_POP_WAIT;
            S_POP_WAIT: state_next = S_NB;
            S_NB:
            begin
                if (nb_live && nb_win)
                begin
                    state_next = S_OFFER_WR;
                end
                else if (nb_last)
                begin
                    state_next = S_POP;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        clr_next    = clr_reg;
        addr_next   = addr_reg;
        cur_next    = cur_reg;
        ent_next    = ent_reg;
        seed_next   = seed_reg;
        dx_next     = dx_reg;
        dy_next     = dy_reg;
        dz_next     = dz_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        cnt_next    = cnt_reg;
        fwin_next   = fwin_reg;
        fovf_next   = fovf_reg;
        done_next   = 1'b0;
        rd_lvl_next = '0;
        stat_next   = ST_OK;
        lmem_we     = 1'b0;
        lmem_addr   = addr_reg;
        lmem_wd     = lmem_rd;
        qmem_we     = 1'b0;

        // step through the 27 offsets, the cell itself included, dx innermost
        if (((state_reg == S_NB) && !(nb_live && nb_win))
            || ((state_reg == S_OFFER_WR) && !seed_reg))
        begin
            if (dx_reg != 2'd2)
            begin
                dx_next = dx_reg + 2'd1;
            end
            else
            begin
                dx_next = '0;
                if (dy_reg != 2'd2)
                begin
                    dy_next = dy_reg + 2'd1;
                end
                else
                begin
                    dy_next = '0;
                    dz_next = dz_reg + 2'd1;
                end
            end
        end

        case (state_reg)
            S_CLEAR:
            begin
                lmem_we   = 1'b1;
                lmem_addr = clr_reg;
                lmem_wd   = '0;
                clr_next  = clr_reg + AW'(1);
            end
            S_DECODE:
            begin
                lmem_addr = cell_addr(iwx_reg, iwz_reg, py_reg);
                addr_next = lmem_addr;
                head_next = '0;
                tail_next = '0;
                cnt_next  = '0;
                fwin_next = 1'b0;
                fovf_next = 1'b0;
                seed_next = 1'b1;
                ent_next  = '{v: lvl_reg, y: py_reg, wz: iwz_reg, wx: iwx_reg};
                if (!inwin_reg)
                begin
                    done_next = 1'b1;
                    stat_next = ST_WINDOW;
                end
                else if ((req_reg == REQ_FILL) && !(seed_region && (lvl_reg != 4'd0)))
                begin
                    done_next = 1'b1;
                end
            end
            S_RMW:
            begin
                done_next = 1'b1;
                case (req_reg)
                    REQ_WR_OPAQUE:
                    begin
                        lmem_we = 1'b1;
                        lmem_wd = {opq_reg, lmem_rd[3:0]};
                    end
                    REQ_WR_LIGHT:
                    begin
                        lmem_we = 1'b1;
                        lmem_wd = {lmem_rd[4], lvl_reg};
                    end
                    REQ_RD_LIGHT: rd_lvl_next = lmem_rd[3:0];
                    default:      ;
                endcase
            end
            S_OFFER_WR:
            begin
                if (lmem_rd[3:0] < ent_reg.v)
                begin
                    lmem_we = 1'b1;
                    lmem_wd = {lmem_rd[4], ent_reg.v};
                    if (seed_reg || !lmem_rd[4])
                    begin
                        if (cnt_reg == (QW+1)'(QUEUE_DEPTH))
                        begin
                            fovf_next = 1'b1;
                        end
                        else
                        begin
                            qmem_we   = 1'b1;
                            tail_next = tail_reg + QW'(1);
                            cnt_next  = cnt_reg + (QW+1)'(1);
                        end
                    end
                end
                seed_next = 1'b0;
            end
            S_POP:
            begin
                if (cnt_reg == '0)
                begin
                    done_next = 1'b1;
                    stat_next = fovf_reg ? ST_OVERFLOW : (fwin_reg ? ST_WINDOW : ST_OK);
                end
                else
                begin
                    head_next = head_reg + QW'(1);
                    cnt_next  = cnt_reg - (QW+1)'(1);
                end
            end
            S_POP_WAIT:
            begin
                cur_next = qmem_rd;
                dx_next  = '0;
                dy_next  = '0;
                dz_next  = '0;
            end
            S_NB:
            begin
                lmem_addr = nb_addr;
                addr_next = nb_addr;
                ent_next  = '{v: cur_reg.v - 4'(nb_dist), y: ny[YW-1:0],
                              wz: nwz[WW-1:0], wx: nwx[WW-1:0]};
                if (nb_live && !nb_win)
                begin
                    fwin_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            head_reg   <= '0;
            tail_reg   <= '0;
            cnt_reg    <= '0;
            seed_reg   <= 1'b0;
            fwin_reg   <= 1'b0;
            fovf_reg   <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            cnt_reg    <= cnt_next;
            seed_reg   <= seed_next;
            fwin_reg   <= fwin_next;
            fovf_reg   <= fovf_next;
            done_reg   <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && start)
        begin
            req_reg   <= req_type;
            px_reg    <= pos_x;
            py_reg    <= pos_y;
            pz_reg    <= pos_z;
            lvl_reg   <= level;
            opq_reg   <= opaque;
            inwin_reg <= in_win;
            iwx_reg   <= in_wx[WW-1:0];
            iwz_reg   <= in_wz[WW-1:0];
        end
        addr_reg   <= addr_next;
        cur_reg    <= cur_next;
        ent_reg    <= ent_next;
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        dz_reg     <= dz_next;
        rd_lvl_reg <= rd_lvl_next;
        stat_reg   <= stat_next;
    end

    assign done       = done_reg;
    assign read_level = rd_lvl_reg;
    assign status     = stat_reg;

endmodule

[sv/vlff_checker.sv]
module vlff_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic [3:0] read_level,
    input logic [1:0] status
);

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without an item in progress");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status != 2'd3))
        else $error("undefined status code");

    a_level_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != 2'd0)) |-> (read_level == 4'd0))
        else $error("read level nonzero on error status");

    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("back to back results");

endmodule

bind voxel_light_flood_fill vlff_checker u_vlff_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .read_level (read_level),
    .status     (status)
);

[verif/tb_voxel_light_flood_fill.sv]
module tb_voxel_light_flood_fill import vlff_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    // cycle budget: clearing pass after reset plus a generous margin for the fills
    localparam longint CYCLE_LIMIT = 30_000_000;
    localparam int     ITEM_GOAL   = 1250;

    typedef struct {
        logic [1:0]         req;
        logic signed [23:0] x;
        logic [6:0]         y;
        logic signed [23:0] z;
        logic [3:0]         lvl;
        logic               op;
    } cell_req_t;

    typedef struct {
        logic [3:0] lvl;
        logic [1:0] st;
    } light_resp_t;

    typedef struct {
        longint wx;
        longint wz;
        longint y;
        int     v;
    } spread_t;

    // light predictor plus the store of expected results
    class light_scoreboard;
        logic signed [19:0] win_x, win_z;
        logic signed [23:0] min_x, end_x, min_z, end_z;
        logic [6:0]         min_y, top_y;
        bit [3:0]           light_lvl [STORE_DEPTH];
        bit                 opac [STORE_DEPTH];
        spread_t            frontier [$];
        light_resp_t        expected [$];
        bit                 hit_window, hit_overflow;
        int                 errors;

        function new();
            win_x = '0; win_z = '0;
            min_x = '0; end_x = '0; min_z = '0; end_z = '0;
            min_y = '0; top_y = 7'd127;
            errors = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                REG_WIN_X: win_x = val[19:0];
                REG_WIN_Z: win_z = val[19:0];
                REG_MIN_X: min_x = val[23:0];
                REG_END_X: end_x = val[23:0];
                REG_MIN_Y: min_y = val[6:0];
                REG_TOP_Y: top_y = val[6:0];
                REG_MIN_Z: min_z = val[23:0];
                REG_END_Z: end_z = val[23:0];
                default: ;
            endcase
        endfunction

        function longint org_x();
            return (longint'(win_x) - 1) * CHUNK_CELLS;
        endfunction

        function longint org_z();
            return (longint'(win_z) - 1) * CHUNK_CELLS;
        endfunction

        function bit in_window(longint x, longint y, longint z);
            longint wx, wz;
            wx = x - org_x();
            wz = z - org_z();
            return wx >= 0 && wx < WIN_CELLS && wz >= 0 && wz < WIN_CELLS &&
                   y >= 0 && y < HEIGHT_LAYERS;
        endfunction

        function int cell_of(longint x, longint y, longint z);
            return int'(((z - org_z()) * WIN_CELLS + (x - org_x())) * HEIGHT_LAYERS + y);
        endfunction

        function void offer(longint x, longint y, longint z, int v, bit seed);
            int idx;
            spread_t e;
            if (x < longint'(min_x) || x >= longint'(end_x)) return;
            if (y < longint'(min_y) || y > longint'(top_y)) return;
            if (z < longint'(min_z) || z >= longint'(end_z)) return;
            if (v <= 0) return;
            if (!in_window(x, y, z))
            begin
                hit_window = 1;
                return;
            end
            idx = cell_of(x, y, z);
            if (int'(light_lvl[idx]) < v)
            begin
                light_lvl[idx] = v[3:0];
                if (seed || !opac[idx])
                begin
                    // a full queue still keeps the new level, only the spread stops
                    if (frontier.size() >= QUEUE_DEPTH)
                        hit_overflow = 1;
                    else
                    begin
                        e.wx = x - org_x();
                        e.wz = z - org_z();
                        e.y  = y;
                        e.v  = v;
                        frontier.insert(frontier.size(), e);
                    end
                end
            end
        endfunction

        function void flood(longint x, longint y, longint z, int v);
            spread_t c;
            frontier.delete();
            offer(x, y, z, v, 1);
            while (frontier.size() > 0)
            begin
                c = frontier.pop_front();
                for (int dz = -1; dz <= 1; dz++)
                    for (int dy = -1; dy <= 1; dy++)
                        for (int dx = -1; dx <= 1; dx++)
                            offer(org_x() + c.wx + dx, c.y + dy, org_z() + c.wz + dz,
                                  c.v - ((dx < 0 ? -dx : dx) + (dy < 0 ? -dy : dy) +
                                         (dz < 0 ? -dz : dz)), 0);
            end
        endfunction

        function void note(cell_req_t r);
            light_resp_t res;
            longint x, y, z;
            int idx;
            x = longint'(r.x);
            y = longint'(r.y);
            z = longint'(r.z);
            res.lvl = '0;
            res.st  = ST_OK;
            if (!in_window(x, y, z))
                res.st = ST_WINDOW;
            else
            begin
                idx = cell_of(x, y, z);
                case (r.req)
                    REQ_WR_OPAQUE: opac[idx] = r.op;
                    REQ_WR_LIGHT:  light_lvl[idx] = r.lvl;
                    REQ_RD_LIGHT:  res.lvl = light_lvl[idx];
                    default:
                    begin
                        hit_window   = 0;
                        hit_overflow = 0;
                        flood(x, y, z, int'(r.lvl));
                        res.st = hit_overflow ? ST_OVERFLOW : (hit_window ? ST_WINDOW : ST_OK);
                    end
                endcase
            end
            expected.insert(expected.size(), res);
        endfunction

        task report_mismatch(string what);
            $display("mismatch: %s", what);
            errors++;
        endtask

        task check(logic [3:0] lvl, logic [1:0] st);
            light_resp_t e;
            if (expected.size() == 0)
                report_mismatch($sformatf("unexpected result level %0d status %0d", lvl, st));
            else
            begin
                e = expected.pop_front();
                if (lvl !== e.lvl)
                    report_mismatch($sformatf("read_level %0d, want %0d", lvl, e.lvl));
                if (st !== e.st)
                    report_mismatch($sformatf("status %0d, want %0d", st, e.st));
            end
        endtask
    endclass

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         req_type;
    logic signed [23:0] pos_x;
    logic [6:0]         pos_y;
    logic signed [23:0] pos_z;
    logic [3:0]         level;
    logic               opaque;
    logic               done;
    logic [3:0]         read_level;
    logic [1:0]         status;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [4:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    light_scoreboard sb;
    int     sent;
    longint cycles;

    // current lit box clipped to the window, used to aim the stimulus
    longint box_x0, box_x1, box_y0, box_y1, box_z0, box_z1;

    voxel_light_flood_fill dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req_type   (req_type),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .pos_z      (pos_z),
        .level      (level),
        .opaque     (opaque),
        .done       (done),
        .read_level (read_level),
        .status     (status),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // results last one cycle and cannot be held off, so take every done strobe
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check(read_level, status);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // setup then access cycle; the write lands on the access edge since pready is high
    task reg_write(logic [2:0] idx, longint val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= 32'(val);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, 32'(val));
    endtask

    function int sender_gap();
        int pct;
        // sender idles 37 in 100 first, then 45, then never
        pct = (sent < ITEM_GOAL / 3) ? 37 : ((sent < 2 * ITEM_GOAL / 3) ? 45 : 0);
        if ($urandom_range(99) < pct)
            return $urandom_range(1, 4);
        return 0;
    endfunction

    // start stays high across back-to-back items; within a send it only drops for a gap
    task send(cell_req_t r);
        int gap;
        req_type <= r.req;
        pos_x    <= r.x;
        pos_y    <= r.y;
        pos_z    <= r.z;
        level    <= r.lvl;
        opaque   <= r.op;
        start    <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note(r);
        sent++;
        gap = sender_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task cmd(logic [1:0] req, longint x, longint y, longint z, int lvl, bit op);
        cell_req_t r;
        r.req = req;
        r.x   = 24'(x);
        r.y   = 7'(y);
        r.z   = 24'(z);
        r.lvl = 4'(lvl);
        r.op  = op;
        send(r);
    endtask

    // quiet the block before touching registers: every result back, then a short margin
    task drain();
        start <= 1'b0;
        while (sb.expected.size() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function longint lmax(longint a, longint b);
        return a > b ? a : b;
    endfunction

    function longint lmin(longint a, longint b);
        return a < b ? a : b;
    endfunction

    // program window and lit box, then give every reachable cell a known opacity
    task set_scene(longint cx, longint cz, longint x0, longint x1, longint y0, longint y1,
                   longint z0, longint z1);
        reg_write(REG_WIN_X, cx);
        reg_write(REG_WIN_Z, cz);
        reg_write(REG_MIN_X, x0);
        reg_write(REG_END_X, x1);
        reg_write(REG_MIN_Y, y0);
        reg_write(REG_TOP_Y, y1);
        reg_write(REG_MIN_Z, z0);
        reg_write(REG_END_Z, z1);
        box_x0 = lmax(longint'(sb.min_x), sb.org_x());
        box_x1 = lmin(longint'(sb.end_x) - 1, sb.org_x() + WIN_CELLS - 1);
        box_y0 = longint'(sb.min_y);
        box_y1 = longint'(sb.top_y);
        box_z0 = lmax(longint'(sb.min_z), sb.org_z());
        box_z1 = lmin(longint'(sb.end_z) - 1, sb.org_z() + WIN_CELLS - 1);
        for (longint x = box_x0; x <= box_x1; x++)
            for (longint y = box_y0; y <= box_y1; y++)
                for (longint z = box_z0; z <= box_z1; z++)
                    cmd(REQ_WR_OPAQUE, x, y, z, $urandom_range(15), $urandom_range(99) < 20);
    endtask

    function cell_req_t random_req();
        cell_req_t r;
        int pick, where;
        bit box_ok;
        longint x, y, z;
        box_ok = box_x0 <= box_x1 && box_y0 <= box_y1 && box_z0 <= box_z1;
        pick  = $urandom_range(99);
        where = $urandom_range(99);
        r.lvl = $urandom_range(15);
        r.op  = $urandom_range(1);
        if (pick < 30)      r.req = REQ_WR_LIGHT;
        else if (pick < 55) r.req = REQ_RD_LIGHT;
        else if (pick < 70) r.req = REQ_WR_OPAQUE;
        else                r.req = REQ_FILL;
        if (box_ok && where < 65)
        begin
            x = box_x0 + $urandom_range(int'(box_x1 - box_x0));
            y = box_y0 + $urandom_range(int'(box_y1 - box_y0));
            z = box_z0 + $urandom_range(int'(box_z1 - box_z0));
        end
        else if (where < 90)
        begin
            x = sb.org_x() + $urandom_range(WIN_CELLS - 1);
            y = $urandom_range(127);
            z = sb.org_z() + $urandom_range(WIN_CELLS - 1);
        end
        else
        begin
            // raw field values, mostly off the window
            x = longint'($signed(24'($urandom)));
            y = $urandom_range(127);
            z = longint'($signed(24'($urandom)));
            r.req = 2'($urandom);
        end
        r.x = 24'(x);
        r.y = 7'(y);
        r.z = 24'(z);
        return r;
    endfunction

    task random_run(int n);
        repeat (n) send(random_req());
    endtask

    initial
    begin
        longint cx, cz, bx, bz, x0, z0, y0;
        sb       = new();
        sent     = 0;
        cycles   = 0;
        rst_n    = 1'b0;
        start    = 1'b0;
        req_type = REQ_RD_LIGHT;
        pos_x    = '0;
        pos_y    = '0;
        pos_z    = '0;
        level    = '0;
        opaque   = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // window around the origin, lit box runs past the window's high x edge;
        // registers may be written during the clearing pass
        set_scene(0, 0, 28, 36, 0, 3, 0, 4);

        // coordinate extremes, all off the window
        cmd(REQ_RD_LIGHT, -8388608, 0, -8388608, 0, 0);
        cmd(REQ_RD_LIGHT, 8388607, 127, 8388607, 15, 1);
        cmd(REQ_WR_LIGHT, 8388607, 127, 8388607, 15, 1);
        // plain write and read back at the top layer
        cmd(REQ_WR_LIGHT, 0, 127, 0, 15, 0);
        cmd(REQ_RD_LIGHT, 0, 127, 0, 0, 0);
        cmd(REQ_WR_LIGHT, 0, 127, 0, 0, 0);
        cmd(REQ_RD_LIGHT, 0, 127, 0, 0, 0);
        cmd(REQ_WR_OPAQUE, -16, 0, -16, 0, 1);
        cmd(REQ_RD_LIGHT, 31, 0, 31, 0, 0);
        // fill with level zero, fill outside the lit box, fill outside the window
        cmd(REQ_FILL, 29, 1, 1, 0, 0);
        cmd(REQ_FILL, 0, 0, 0, 15, 0);
        cmd(REQ_FILL, 100, 0, 0, 15, 0);
        // opaque seed still spreads; light reaching past the window edge flags it
        cmd(REQ_WR_OPAQUE, 29, 1, 1, 0, 1);
        cmd(REQ_FILL, 29, 1, 1, 15, 0);
        cmd(REQ_RD_LIGHT, 31, 3, 3, 0, 0);
        cmd(REQ_RD_LIGHT, 28, 0, 0, 0, 0);
        // dimmer fill on lit cells changes nothing
        cmd(REQ_FILL, 30, 2, 2, 9, 0);
        cmd(REQ_WR_LIGHT, 28, 3, 3, 3, 0);
        cmd(REQ_FILL, 31, 0, 0, 15, 0);
        cmd(REQ_RD_LIGHT, 28, 3, 3, 0, 0);
        random_run(60);
        drain();

        // window at the highest chunk, box at the top layers and top x edge
        set_scene(524287, 0, 8388602, 8388607, 123, 127, -16, -11);
        random_run(120);
        drain();

        // window at the lowest chunk, box at the bottom layers and low edges
        set_scene(-524288, -524288, -8388608, -8388603, 0, 4, -8388608, -8388603);
        random_run(120);
        drain();

        // empty lit box: top below bottom
        set_scene(3, -7, 0, 100, 100, 50, -200, 100);
        random_run(40);
        drain();

        repeat (5)
        begin
            cx = longint'($urandom_range(800000)) - 400000;
            cz = longint'($urandom_range(800000)) - 400000;
            bx = (cx - 1) * CHUNK_CELLS;
            bz = (cz - 1) * CHUNK_CELLS;
            // box of a few cells, sometimes hanging over a window edge
            x0 = bx + longint'($urandom_range(49)) - 2;
            z0 = bz + longint'($urandom_range(49)) - 2;
            y0 = $urandom_range(123);
            set_scene(cx, cz, x0, x0 + $urandom_range(2, 5), y0, y0 + $urandom_range(1, 4),
                      z0, z0 + $urandom_range(2, 5));
            random_run(70);
            drain();
        end

        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.expected.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
